// ===== hdl/zbi_pkg.sv =====
// Package for the zero-bit insertion index block.
// Holds the word type that carries the index through the cell row; no dependencies.
package zbi_pkg;

  // Widest index the block supports; the cells carry words of this size.
  localparam int unsigned MaxIndexWidth = 64;

  typedef logic [MaxIndexWidth-1:0] word_t;

endpackage

// ===== hdl/zbi_cell.sv =====
// One cell of the deposit row: owns a single result bit position.
// Depends on zbi_pkg for the word type.
module zbi_cell import zbi_pkg::*; #(
  parameter int unsigned BitPos = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  skip_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  word_t in_src_i,
  input  word_t in_res_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output word_t out_src_o,
  output word_t out_res_o
);

  logic  valid_q, valid_d;
  word_t src_q, src_d;
  word_t res_q, res_d;
  logic  load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // A free position takes the lowest remaining compact bit and consumes it;
  // a skipped position keeps zero and leaves the compact bits untouched.
  always_comb begin
    valid_d = valid_q;
    src_d   = src_q;
    res_d   = res_q;
    if (load) begin
      valid_d = 1'b1;
      if (skip_i) begin
        src_d = in_src_i;
        res_d = in_res_i;
      end else begin
        src_d = in_src_i >> 1;
        res_d = in_res_i;
        res_d[BitPos] = in_src_i[0];
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign out_src_o   = src_q;
  assign out_res_o   = res_q;

endmodule

// ===== hdl/zero_bit_insertion_index.sv =====
// Top level of the zero-bit insertion index block: skip mask register and the cell row.
// Depends on zbi_pkg and zbi_cell.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   perm_index_i
//   result    out        out_valid_o / out_stall_i spread_index_o
//   config    in         skip_mask_we_i            skip_mask_i
//
// One item enters per cycle while in_stall_o is low; each item passes through the cell row,
// one cell per output bit position, the last cell acting as the output register.
// Reset clears the skip mask and empties every cell.
// A stalled result holds the last cell; earlier cells keep filling until the row is full,
// and only then is in_stall_o raised (the ready chain runs combinationally through the row).
module zero_bit_insertion_index import zbi_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   skip_mask_we_i,
  input  logic [INDEX_WIDTH-1:0] skip_mask_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [INDEX_WIDTH-1:0] perm_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [INDEX_WIDTH-1:0] spread_index_o
);

  logic [INDEX_WIDTH-1:0] skip_q, skip_d;

  logic  link_valid [INDEX_WIDTH+1];
  logic  link_ready [INDEX_WIDTH+1];
  word_t link_src   [INDEX_WIDTH+1];
  word_t link_res   [INDEX_WIDTH+1];
  logic [INDEX_WIDTH-1:0] cell_valid;

  always_comb begin
    skip_d = skip_q;
    if (skip_mask_we_i) begin
      skip_d = skip_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
    end else begin
      skip_q <= skip_d;
    end
  end

  assign link_valid[0]           = in_valid_i;
  assign link_src[0]             = word_t'(perm_index_i);
  assign link_res[0]             = '0;
  assign link_ready[INDEX_WIDTH] = !out_stall_i;

  for (genvar k = 0; k < INDEX_WIDTH; k++) begin : g_cell
    zbi_cell #(
      .BitPos(k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .skip_i     (skip_q[k]),
      .in_valid_i (link_valid[k]),
      .in_ready_o (link_ready[k]),
      .in_src_i   (link_src[k]),
      .in_res_i   (link_res[k]),
      .out_valid_o(link_valid[k+1]),
      .out_ready_i(link_ready[k+1]),
      .out_src_o  (link_src[k+1]),
      .out_res_o  (link_res[k+1])
    );
    assign cell_valid[k] = link_valid[k+1];
  end

  assign in_stall_o     = !link_ready[0];
  assign out_valid_o    = link_valid[INDEX_WIDTH];
  assign spread_index_o = link_res[INDEX_WIDTH][INDEX_WIDTH-1:0];

  // The input stalls only when every cell holds an item and the result is stalled.
  a_stall_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&cell_valid) && out_stall_i)
  ) else $error("input stalled while the cell row has room");

  // An item taken in with nothing leaving raises the occupancy by exactly one.
  a_occupancy_grows : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !(out_valid_o && !out_stall_i))
      |=> ($countones(cell_valid) == $past($countones(cell_valid)) + 1)
  ) else $error("accepted item lost or duplicated in the cell row");

  // An item delivered with nothing entering lowers the occupancy by exactly one.
  a_occupancy_shrinks : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!(in_valid_i && !in_stall_o) && out_valid_o && !out_stall_i)
      |=> ($countones(cell_valid) + 1 == $past($countones(cell_valid)))
  ) else $error("delivered item not removed from the cell row");

  // Skipped positions always come out as zero.
  a_skipped_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((spread_index_o & skip_q) == '0)
  ) else $error("nonzero bit at a skipped position");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for zero_bit_insertion_index: bursty indexes, random result stalls, skip mask phases.
// Every result is checked against a bit-deposit predictor; depends on zbi_pkg and the block.
`timescale 1ns / 1ps

module testbench;
  import zbi_pkg::*;

  localparam int unsigned IndexWidth = MaxIndexWidth;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned PhaseItems = 122;
  localparam int unsigned RandomPhases = 8;

  typedef enum int unsigned {StallNone, StallHalf, StallRare, StallHeavy} stall_mode_e;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  skip_mask_we = 1'b0;
  word_t skip_mask = '0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t perm_index = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t spread_index;

  word_t pending_index[$];
  word_t spread_expected[$];
  word_t skip_now = '0;
  logic  random_part = 1'b0;
  int unsigned error_count = 0;
  int unsigned inputs_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mask_settings = 0;

  word_t dir_masks [6] = '{'0, '1, word_t'(1), word_t'(1) << (IndexWidth - 1),
                           {(IndexWidth / 2){2'b10}},
                           {{(IndexWidth / 2){1'b1}}, {(IndexWidth / 2){1'b0}}}};
  word_t dir_indexes [4] = '{'0, '1, word_t'(1) << (IndexWidth - 1),
                             {(IndexWidth / 2){2'b01}}};

  zero_bit_insertion_index #(
    .INDEX_WIDTH(IndexWidth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .skip_mask_we_i(skip_mask_we),
    .skip_mask_i   (skip_mask),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .perm_index_i  (perm_index),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .spread_index_o(spread_index)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Walk the positions upward; each free position takes the next compact bit.
  function automatic word_t deposit_bits(word_t idx, word_t skip);
    word_t spread;
    int unsigned next;
    spread = '0;
    next = 0;
    for (int unsigned pos = 0; pos < IndexWidth; pos++) begin
      if (!skip[pos]) begin
        spread[pos] = idx[next];
        next++;
      end
    end
    return spread;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int unsigned lo;
    int unsigned hi;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: w = word_t'($urandom_range(0, 255));
      1: w = word_t'(1) << $urandom_range(0, IndexWidth - 1);
      2: w = ~(word_t'(1) << $urandom_range(0, IndexWidth - 1));
      3: w = w & {$urandom(), $urandom()} & {$urandom(), $urandom()};
      4: begin
        lo = $urandom_range(0, IndexWidth - 1);
        hi = $urandom_range(0, IndexWidth - 1 - lo);
        w = ('1 << lo) & ('1 >> hi);
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic wait_drained();
    while (pending_index.size() != 0 || spread_expected.size() != 0) @(posedge clk_i);
    repeat (IndexWidth + 2) @(posedge clk_i);
  endtask

  task automatic load_skip_mask(input word_t m);
    wait_drained();
    @(posedge clk_i);
    skip_mask_we <= 1'b1;
    skip_mask <= m;
    skip_now = m;
    mask_settings++;
    @(posedge clk_i);
    skip_mask_we <= 1'b0;
    // Items are queued away from the clock edge so the driver sees a settled queue.
    @(negedge clk_i);
  endtask

  initial begin
    word_t m;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_masks[i]) begin
      load_skip_mask(dir_masks[i]);
      foreach (dir_indexes[j]) pending_index.insert(pending_index.size(), dir_indexes[j]);
    end

    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: m = '0;
        1: m = '1;
        default: m = rand_word();
      endcase
      load_skip_mask(m);
      random_part = 1'b1;
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        pending_index.insert(pending_index.size(), rand_word());
      end
    end

    wait_drained();
    if (spread_expected.size() != 0) note_error("results still outstanding at the end");
    $display("Summary: %0d items and %0d results over %0d skip mask settings,",
             inputs_accepted, results_checked, mask_settings);
    $display("with bursty input, random result stalls and two long result hold-offs.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Driver: bursts of random length separated by random gaps, some of them zero.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap_left;
    int unsigned burst_left;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      perm_index <= '0;
      gap_left = 0;
      burst_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) pending_index.delete(0);
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_index.size() != 0) begin
        in_valid <= 1'b1;
        perm_index <= pending_index[0];
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes per segment; twice it holds off long enough to fill the row.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned hold_left;
    int unsigned holds_taken;
    int unsigned seg_left;
    stall_mode_e stall_mode;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      holds_taken = 0;
      seg_left = 0;
      stall_mode = StallNone;
    end else begin
      if (hold_left == 0 && holds_taken < 2 && random_part && pending_index.size() > 100) begin
        hold_left = HoldCycles;
        holds_taken++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 100);
          stall_mode = stall_mode_e'($urandom_range(0, 3));
        end
        seg_left--;
        case (stall_mode)
          StallNone: out_stall <= 1'b0;
          StallHalf: out_stall <= ($urandom_range(0, 1) == 1);
          StallRare: out_stall <= ($urandom_range(0, 7) == 0);
          default:   out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Monitor: predict on each accepted item, compare each accepted result with the oldest.
  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        spread_expected.insert(spread_expected.size(), deposit_bits(perm_index, skip_now));
        inputs_accepted++;
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (spread_expected.size() == 0) begin
          note_error($sformatf("result %h arrived with no item outstanding", spread_index));
        end else begin
          want = spread_expected.pop_front();
          if (spread_index !== want) begin
            note_error($sformatf("spread_index expected %h, got %h", want, spread_index));
          end
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    int unsigned idle_cycles;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no item moved for %0d cycles", IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
